### hdl/mlpq_pkg.sv
// Package for the multilevel priority queue.
// Holds request and status codes, controller states and the command/status structs.
package mlpq_pkg;

  typedef enum logic [1:0] {
    REQ_ENQ    = 2'd0,
    REQ_DEQ    = 2'd1,
    REQ_PEEK   = 2'd2,
    REQ_REMOVE = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_NOMATCH = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_POLICY_MAP = 2'd0,
    CFG_LEVELS     = 2'd1,
    CFG_NONE_A     = 2'd2,
    CFG_NONE_B     = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_CHECK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DONE
  } state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;       // capture request, clear level and position
    logic next_level; // advance to next level, position back to zero
    logic issue_rd;   // read memory at current level and position
    logic next_pos;   // advance position
    logic shift_wr;   // write read data to position minus one
    logic enq_wr;     // append thread id to current level
    logic dec_count;  // drop one entry from current level
    logic finish;     // load result register
    status_e st;      // status to report on finish
    logic id_valid;   // report a result id on finish
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    req_e req;
    logic lvl_active;   // current level is below the active count
    logic policy_hit;   // current level policy equals thread policy
    logic lvl_nonempty; // current level holds entries
    logic lvl_full;     // current level holds LEVEL_DEPTH entries
    logic pos_in_range; // position below the level count
    logic id_match;     // read data equals thread id
    logic last_lvl;     // current level is the final one
  } stat_t;

endpackage

### hdl/multilevel_priority_queue_top.sv
// Multilevel priority queue of thread ids.
// Slave stream s_axis carries one request a beat; master stream m_axis
// returns one result per request. Configuration goes through a write port
// (index 0: level policy map, index 1: levels in use), to be written by the
// user only idle; the block itself does not enforce this.
// A request is taken only when the block is idle and no result is waiting.
// Enqueue and the empty or no-match cases scan level by level; peek and
// dequeue then read the head of the level found; remove reads, waits and
// compares for every entry it checks. Dequeue and remove then close the
// gap while the result is out, reading and writing each entry behind the
// removed one. The entry memory has registered reads.
// The next request is taken only after the result beat is taken and the
// gap is closed, so a new request waits until the last one is through.
// Reset empties every level and restores policy map 0x3210 and four levels;
// entry memory contents are not cleared, no clearing pass is needed.
// A stalled receiver holds the result on m_axis and blocks new requests.
module multilevel_priority_queue_top
  import mlpq_pkg::*;
#(
  parameter int NUM_LEVELS  = 4,
  parameter int LEVEL_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // req_type[1:0], tid[17:2], thread_policy[21:18]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata   // status[1:0], result_id[17:2], result_level[19:18]
);

  cmd_t  cmd;
  stat_t stat;
  logic  idle;
  logic  vld_q;
  logic [1:0]  st;
  logic [15:0] rid;
  logic [1:0]  rlvl;

  assign s_axis_tready = idle && !vld_q;

  mlpq_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .start_i   (s_axis_tvalid && s_axis_tready),
    .out_busy_i(vld_q && !m_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd),
    .idle_o    (idle)
  );

  mlpq_dpath #(.NUM_LEVELS(NUM_LEVELS), .LEVEL_DEPTH(LEVEL_DEPTH)) u_dpath (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .req_i       (s_axis_tdata[1:0]),
    .id_i        (s_axis_tdata[17:2]),
    .pol_i       (s_axis_tdata[21:18]),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .res_status_o(st),
    .res_id_o    (rid),
    .res_level_o (rlvl)
  );

  // Raise the result beat after finish, drop it when taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else if (cmd.finish) vld_q <= 1'b1;
    else if (m_axis_tready) vld_q <= 1'b0;
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = {4'd0, rlvl, rid, st};

endmodule

### hdl/mlpq_ctrl.sv
// Controller state machine for the multilevel priority queue.
// Depends on mlpq_pkg; drives commands into mlpq_dpath.
module mlpq_ctrl
  import mlpq_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  logic  out_busy_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o,
  output logic  idle_o
);

  state_e state_q, state_d;

  // Advance state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!stat_i.lvl_active) begin
          state_d = S_DONE;
        end else begin
          unique case (stat_i.req)
            REQ_ENQ: begin
              if (stat_i.policy_hit || stat_i.last_lvl) state_d = S_DONE;
            end
            REQ_DEQ, REQ_PEEK: begin
              if (stat_i.lvl_nonempty) state_d = S_READ;
              else if (stat_i.last_lvl) state_d = S_DONE;
            end
            REQ_REMOVE: begin
              if (stat_i.pos_in_range) state_d = S_READ;
              else if (stat_i.last_lvl) state_d = S_DONE;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_READ: state_d = S_CHECK;
      S_CHECK: begin
        if (stat_i.req != REQ_REMOVE) begin
          if (stat_i.req == REQ_DEQ) begin
            state_d = S_SHIFT_RD;
          end else begin
            state_d = S_DONE;
          end
        end else if (stat_i.id_match) begin
          state_d = S_SHIFT_RD;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SHIFT_RD: state_d = stat_i.pos_in_range ? S_SHIFT_WR : S_DONE;
      S_SHIFT_WR: state_d = S_SHIFT_RD;
      S_DONE:     if (!out_busy_i) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o    = '0;
    cmd_o.st = ST_OK;
    unique case (state_q)
      S_IDLE: cmd_o.load = start_i;
      S_SCAN: begin
        if (stat_i.lvl_active) begin
          unique case (stat_i.req)
            REQ_ENQ: begin
              if (stat_i.policy_hit) begin
                cmd_o.finish = 1'b1;
                if (stat_i.lvl_full) cmd_o.st = ST_FULL;
                else cmd_o.enq_wr = 1'b1;
              end else if (stat_i.last_lvl) begin
                cmd_o.finish = 1'b1;
                cmd_o.st     = ST_NOMATCH;
              end else begin
                cmd_o.next_level = 1'b1;
              end
            end
            REQ_DEQ, REQ_PEEK: begin
              if (stat_i.lvl_nonempty) cmd_o.issue_rd = 1'b1;
              else if (stat_i.last_lvl) begin
                cmd_o.finish = 1'b1;
                cmd_o.st     = ST_EMPTY;
              end else cmd_o.next_level = 1'b1;
            end
            REQ_REMOVE: begin
              if (stat_i.pos_in_range) cmd_o.issue_rd = 1'b1;
              else if (stat_i.last_lvl) begin
                cmd_o.finish = 1'b1;
                cmd_o.st     = ST_EMPTY;
              end else cmd_o.next_level = 1'b1;
            end
            default: ;
          endcase
        end else begin
          cmd_o.finish = 1'b1;
          cmd_o.st     = (stat_i.req == REQ_ENQ) ? ST_NOMATCH : ST_EMPTY;
        end
      end
      S_CHECK: begin
        if (stat_i.req == REQ_PEEK) begin
          cmd_o.finish   = 1'b1;
          cmd_o.id_valid = 1'b1;
        end else if (stat_i.req == REQ_DEQ || stat_i.id_match) begin
          cmd_o.finish   = 1'b1;
          cmd_o.id_valid = 1'b1;
          cmd_o.next_pos = 1'b1;
        end else begin
          cmd_o.next_pos = 1'b1;
        end
      end
      S_SHIFT_RD: begin
        if (stat_i.pos_in_range) cmd_o.issue_rd = 1'b1;
        else cmd_o.dec_count = 1'b1;
      end
      S_SHIFT_WR: begin
        cmd_o.shift_wr = 1'b1;
        cmd_o.next_pos = 1'b1;
      end
      default: ;
    endcase
  end

  assign idle_o = (state_q == S_IDLE);

`ifndef NO_ASSERTIONS
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> state_q == S_IDLE) else $error("load outside idle");
  a_wr_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.enq_wr && cmd_o.shift_wr)) else $error("two memory writes");
  a_shift_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.dec_count |-> state_q == S_SHIFT_RD) else $error("stray count decrement");
`endif

endmodule

### hdl/mlpq_dpath.sv
// Datapath of the multilevel priority queue: entry memory, level counts,
// config registers and result register. Depends on mlpq_pkg.
module mlpq_dpath
  import mlpq_pkg::*;
#(
  parameter int NUM_LEVELS  = 4,
  parameter int LEVEL_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic [1:0]  req_i,
  input  logic [15:0] id_i,
  input  logic [3:0]  pol_i,
  input  cmd_t        cmd_i,
  output stat_t       stat_o,
  output logic [1:0]  res_status_o,
  output logic [15:0] res_id_o,
  output logic [1:0]  res_level_o
);

  localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int PW = $clog2(LEVEL_DEPTH);
  localparam int CW = $clog2(LEVEL_DEPTH + 1);
  localparam int AW = LW + PW;
  localparam int MaxAct = (NUM_LEVELS < 4) ? NUM_LEVELS : 4;

  logic [15:0] map_q;
  logic [2:0]  lvls_q;
  req_e        req_q;
  logic [15:0] id_q;
  logic [3:0]  pol_q;
  logic [1:0]  lvl_q;     // levels beyond four are never active
  logic [CW-1:0] pos_q;
  logic [CW-1:0] cnt_q [NUM_LEVELS];
  logic [15:0] mem [2**AW];
  logic [15:0] rd_q;
  logic [1:0]  st_q;
  logic [15:0] rid_q;
  logic [1:0]  rlvl_q;

  logic [2:0]    nact;
  logic [LW-1:0] li;
  logic [CW-1:0] cur_cnt;
  logic [3:0]    cur_pol;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [CW-1:0] pos_m1;

  // Active level limit and current level lookups.
  assign nact    = (lvls_q > 3'(MaxAct)) ? 3'(MaxAct) : lvls_q;
  assign li      = LW'(lvl_q);
  assign cur_cnt = cnt_q[li];
  assign cur_pol = map_q[{lvl_q, 2'b00} +: 4];
  assign pos_m1  = pos_q - CW'(1);
  assign rd_addr = {li, pos_q[PW-1:0]};
  assign wr_addr = cmd_i.enq_wr ? {li, cur_cnt[PW-1:0]} : {li, pos_m1[PW-1:0]};

  always_comb begin
    stat_o.req          = req_q;
    stat_o.lvl_active   = {1'b0, lvl_q} < nact;
    stat_o.policy_hit   = cur_pol == pol_q;
    stat_o.lvl_nonempty = cur_cnt != '0;
    stat_o.lvl_full     = cur_cnt == CW'(LEVEL_DEPTH);
    stat_o.pos_in_range = pos_q < cur_cnt;
    stat_o.id_match     = rd_q == id_q;
    stat_o.last_lvl     = {1'b0, lvl_q} + 3'd1 >= nact;
  end

  // Hold config registers and level counts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q  <= 16'h3210;
      lvls_q <= 3'd4;
      for (int i = 0; i < NUM_LEVELS; i++) cnt_q[i] <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_i == CFG_POLICY_MAP) map_q <= cfg_data_i;
      if (cfg_we_i && cfg_idx_i == CFG_LEVELS) lvls_q <= cfg_data_i[2:0];
      if (cmd_i.enq_wr) cnt_q[li] <= cur_cnt + CW'(1);
      else if (cmd_i.dec_count) cnt_q[li] <= cur_cnt - CW'(1);
    end
  end

  // Capture request, walk level and position, load result.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_e'(req_i);
      id_q  <= id_i;
      pol_q <= pol_i;
      lvl_q <= 2'd0;
      pos_q <= '0;
    end else if (cmd_i.next_level) begin
      lvl_q <= lvl_q + 2'd1;
      pos_q <= '0;
    end else if (cmd_i.next_pos && !(req_q == REQ_REMOVE && !stat_o.id_match
                 && pos_q + CW'(1) >= cur_cnt && !stat_o.last_lvl
                 && !cmd_i.finish && !cmd_i.shift_wr)) begin
      pos_q <= pos_q + CW'(1);
    end else if (cmd_i.next_pos) begin
      // Remove miss at end of level: move to next level.
      lvl_q <= lvl_q + 2'd1;
      pos_q <= '0;
    end
    if (cmd_i.finish) begin
      st_q   <= cmd_i.st;
      rid_q  <= cmd_i.id_valid ? rd_q : 16'd0;
      rlvl_q <= (cmd_i.st == ST_EMPTY || cmd_i.st == ST_NOMATCH) ? 2'd0 : lvl_q;
    end
  end

  // Entry memory: one write and one registered read a cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.enq_wr) mem[wr_addr] <= id_q;
    else if (cmd_i.shift_wr) mem[wr_addr] <= rd_q;
    if (cmd_i.issue_rd) rd_q <= mem[rd_addr];
  end

  assign res_status_o = st_q;
  assign res_id_o     = rid_q;
  assign res_level_o  = rlvl_q;

endmodule

### tb/multilevel_priority_queue_checker.sv
// Checker for the multilevel priority queue: watches both stream channels,
// predicts each result beat and compares it field by field.
// Depends on mlpq_pkg for request and status codes.
module multilevel_priority_queue_checker
  import mlpq_pkg::*;
#(
  parameter int NUM_LEVELS  = 4,
  parameter int LEVEL_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,
  output int          fail_cnt_o,
  output int          pending_o,
  output int          result_cnt_o
);

  typedef struct packed {
    status_e     st;
    logic [15:0] id;
    logic [1:0]  lvl;
  } sched_res_t;

  logic [15:0] policy_map;
  logic [2:0]  levels_used;
  logic [15:0] lvl_entries [NUM_LEVELS][LEVEL_DEPTH];
  int          lvl_fill [NUM_LEVELS];
  sched_res_t  res_queue [$];

  assign pending_o = res_queue.size();

  function automatic int active_cnt();
    int n;
    n = levels_used;
    if (n > NUM_LEVELS) n = NUM_LEVELS;
    if (n > 4) n = 4;
    return n;
  endfunction

  // Drop entry pos of level l and close the gap.
  task automatic drop_entry(int l, int pos);
    for (int k = pos; k + 1 < lvl_fill[l]; k++) lvl_entries[l][k] = lvl_entries[l][k + 1];
    lvl_fill[l]--;
  endtask

  // Apply one request to the shadow queues and return its result.
  task automatic schedule_req(input req_e req, input logic [15:0] tid,
                              input logic [3:0] pol, output sched_res_t r);
    int nact;
    bit done;
    nact = active_cnt();
    done = 0;
    r = '{st: ST_EMPTY, id: 16'd0, lvl: 2'd0};
    case (req)
      REQ_ENQ: begin
        r.st = ST_NOMATCH;
        for (int l = 0; l < nact && !done; l++) begin
          if (policy_map[4*l +: 4] == pol) begin
            done = 1;
            r.lvl = l[1:0];
            if (lvl_fill[l] >= LEVEL_DEPTH) begin
              r.st = ST_FULL;
            end else begin
              lvl_entries[l][lvl_fill[l]] = tid;
              lvl_fill[l]++;
              r.st = ST_OK;
            end
          end
        end
      end
      REQ_DEQ, REQ_PEEK: begin
        for (int l = 0; l < nact && !done; l++) begin
          if (lvl_fill[l] != 0) begin
            done = 1;
            r = '{st: ST_OK, id: lvl_entries[l][0], lvl: l[1:0]};
            if (req == REQ_DEQ) drop_entry(l, 0);
          end
        end
      end
      default: begin
        for (int l = 0; l < nact && !done; l++) begin
          for (int k = 0; k < lvl_fill[l] && !done; k++) begin
            if (lvl_entries[l][k] == tid) begin
              done = 1;
              drop_entry(l, k);
              r = '{st: ST_OK, id: tid, lvl: l[1:0]};
            end
          end
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sched_res_t exp_r, got_r;
    if (!rst_ni) begin
      policy_map  = 16'h3210;
      levels_used = 3'd4;
      for (int l = 0; l < NUM_LEVELS; l++) lvl_fill[l] = 0;
      res_queue.delete();
      fail_cnt_o   <= 0;
      result_cnt_o <= 0;
    end else begin
      // Track register writes.
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_POLICY_MAP) policy_map = cfg_data_i;
        else if (cfg_idx_i == CFG_LEVELS) levels_used = cfg_data_i[2:0];
      end
      // Predict on each request beat.
      if (s_axis_tvalid && s_axis_tready) begin
        schedule_req(req_e'(s_axis_tdata[1:0]), s_axis_tdata[17:2],
                     s_axis_tdata[21:18], exp_r);
        res_queue.push_back(exp_r);
      end
      // Compare each result beat with the oldest prediction.
      if (m_axis_tvalid && m_axis_tready) begin
        got_r = '{st: status_e'(m_axis_tdata[1:0]), id: m_axis_tdata[17:2],
                  lvl: m_axis_tdata[19:18]};
        result_cnt_o <= result_cnt_o + 1;
        if (res_queue.size() == 0) begin
          $error("unexpected result beat %h", m_axis_tdata);
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          exp_r = res_queue.pop_front();
          if (got_r.st != exp_r.st || got_r.id != exp_r.id || got_r.lvl != exp_r.lvl)
            fail_cnt_o <= fail_cnt_o + 1;
          if (got_r.st != exp_r.st)
            $error("status: expected %0d, got %0d", exp_r.st, got_r.st);
          if (got_r.id != exp_r.id)
            $error("result_id: expected %h, got %h", exp_r.id, got_r.id);
          if (got_r.lvl != exp_r.lvl)
            $error("result_level: expected %0d, got %0d", exp_r.lvl, got_r.lvl);
        end
      end
    end
  end

endmodule

### tb/multilevel_priority_queue_top_tb.sv
// Testbench top for the multilevel priority queue: clock, reset, request
// stimulus, register phases and verdict. Depends on mlpq_pkg and the checker.
module multilevel_priority_queue_top_tb;
  import mlpq_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;  // req_type[1:0], tid[17:2], thread_policy[21:18]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;       // status[1:0], result_id[17:2], result_level[19:18]
  int          fail_cnt, pending, result_cnt;
  int          cycle_cnt = 0;
  int          req_cnt = 0;
  logic [15:0] recent_ids [8];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  multilevel_priority_queue_top dut (.*);

  multilevel_priority_queue_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_cnt_o(fail_cnt), .pending_o(pending), .result_cnt_o(result_cnt)
  );

  // Stall the result side at random per beat.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Hold valid after a beat when the next one follows at once.
  task automatic send_req(req_e req, logic [15:0] tid, logic [3:0] pol, bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= {2'b00, pol, tid, req};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    recent_ids[req_cnt % 8] = tid;
    req_cnt++;
  endtask

  // Wait until every result is back and the block is idle, then settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || !s_axis_tready) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Random phase: mostly enqueues and well-formed removes of known ids.
  task automatic random_phase(int n);
    req_e r;
    logic [15:0] tid;
    bit burst;
    for (int i = 0; i < n; i++) begin
      burst = ($urandom_range(0, 9) < 3);
      r = req_e'($urandom_range(0, 3));
      if ($urandom_range(0, 9) < 4) r = REQ_ENQ;
      tid = 16'($urandom());
      if (r == REQ_REMOVE && $urandom_range(0, 3) != 0) tid = recent_ids[$urandom_range(0, 7)];
      if ($urandom_range(0, 7) == 0) tid = 16'($urandom_range(0, 3));
      send_req(r, tid, 4'($urandom_range(0, 15)), burst);
    end
  endtask

  initial begin
    for (int i = 0; i < 8; i++) recent_ids[i] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty queue, extremes, level full, duplicates.
    send_req(REQ_DEQ, 16'h0000, 4'h0, 0);
    send_req(REQ_PEEK, 16'hFFFF, 4'hF, 0);
    send_req(REQ_REMOVE, 16'hFFFF, 4'h0, 0);
    send_req(REQ_ENQ, 16'hFFFF, 4'hF, 0);
    for (int i = 0; i < 17; i++) send_req(REQ_ENQ, 16'(i), 4'h1, 1);
    send_req(REQ_ENQ, 16'hFFFF, 4'h0, 0);
    send_req(REQ_ENQ, 16'h0005, 4'h0, 0);
    send_req(REQ_REMOVE, 16'h0005, 4'h0, 0);
    send_req(REQ_PEEK, 16'h0000, 4'h0, 0);
    send_req(REQ_DEQ, 16'h0000, 4'h0, 0);
    send_req(REQ_REMOVE, 16'h0005, 4'h0, 0);
    send_req(REQ_REMOVE, 16'h000F, 4'h0, 0);
    drain();

    // Zero levels, then one level: hidden entries.
    write_reg(CFG_LEVELS, 16'd0);
    send_req(REQ_ENQ, 16'h1234, 4'h0, 0);
    send_req(REQ_DEQ, 16'h0000, 4'h0, 0);
    send_req(REQ_REMOVE, 16'h0003, 4'h0, 0);
    drain();
    write_reg(CFG_LEVELS, 16'd1);
    random_phase(200);
    drain();

    // Policy maps across extremes, all levels, then beyond range of levels.
    write_reg(CFG_LEVELS, 16'd4);
    write_reg(CFG_POLICY_MAP, 16'hFFFF);
    random_phase(150);
    drain();
    write_reg(CFG_POLICY_MAP, 16'h0000);
    write_reg(CFG_LEVELS, 16'd7);
    random_phase(150);
    drain();
    write_reg(CFG_POLICY_MAP, 16'h3210);
    random_phase(350);
    drain();
    for (int p = 0; p < 4; p++) begin
      write_reg(CFG_POLICY_MAP, 16'($urandom()) | 16'h0003);
      write_reg(CFG_LEVELS, 16'($urandom_range(1, 4)));
      random_phase(150);
      drain();
    end

    $display("Ran %0d requests over several policy maps and level counts; %0d results checked.",
             req_cnt, result_cnt);
    if (fail_cnt == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
